[design/bxr_pkg.sv]
// Shared constants and types for the ray against box hit test.
package bxr_pkg;

   localparam int DIST_W    = 31;
   localparam int NUM_FACES = 6;
   localparam int NUM_AXES  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIST_W-1:0] HALF_RESET = 31'd65536;

   typedef enum logic [2:0] {
      FACE_PX = 3'd0,
      FACE_NX = 3'd1,
      FACE_PY = 3'd2,
      FACE_NY = 3'd3,
      FACE_PZ = 3'd4,
      FACE_NZ = 3'd5
   } face_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_X = 2'd0,
      CSR_HALF_Y = 2'd1,
      CSR_HALF_Z = 2'd2
   } csr_type;

endpackage

[design/bxr_div.sv]
// Pipelined signed divider producing one quotient bit per stage with range check.
module bxr_div import bxr_pkg::*; #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 32
) (
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DEN_W-1:0] den,
   output logic [DIST_W-1:0]       t,
   output logic                    ok
);

   localparam int RW = ((NUM_W > DEN_W + DIST_W) ? NUM_W : DEN_W + DIST_W) + 1;

   logic [NUM_W-1:0]  mnum_ff;
   logic [DEN_W-1:0]  mden_ff;
   logic              neg_ff;
   logic              dz_ff;
   logic [RW-1:0]     rem_ff [DIST_W+1];
   logic [RW-1:0]     dv_ff  [DIST_W+1];
   logic [DIST_W-1:0] q_ff   [DIST_W+1];
   logic              negp_ff [DIST_W+1];
   logic              bad_ff  [DIST_W+1];
   logic [RW-1:0]     rem0_in;
   logic [RW-1:0]     dv0_in;
   logic              bad0_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         mnum_ff <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         mden_ff <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
         neg_ff  <= num[NUM_W-1] ^ den[DEN_W-1];
         dz_ff   <= (den == '0);
      end
   end

   always_comb begin
      rem0_in = {{(RW-NUM_W){1'b0}}, mnum_ff};
      dv0_in  = {{(RW-DEN_W){1'b0}}, mden_ff};
      bad0_in = dz_ff | (rem0_in >= (dv0_in << DIST_W));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= rem0_in;
         dv_ff[0]   <= dv0_in;
         q_ff[0]    <= '0;
         negp_ff[0] <= neg_ff;
         bad_ff[0]  <= bad0_in;
      end
   end

   for (genvar s = 0; s < DIST_W; s++) begin : g_step
      localparam int B = DIST_W - 1 - s;
      logic [RW-1:0]     trial;
      logic [RW-1:0]     rem_in;
      logic [DIST_W-1:0] q_in;

      always_comb begin
         trial  = dv_ff[s] << B;
         rem_in = rem_ff[s];
         q_in   = q_ff[s];
         if (rem_ff[s] >= trial) begin
            rem_in  = rem_ff[s] - trial;
            q_in[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s+1]  <= rem_in;
            dv_ff[s+1]   <= dv_ff[s];
            q_ff[s+1]    <= q_in;
            negp_ff[s+1] <= negp_ff[s];
            bad_ff[s+1]  <= bad_ff[s];
         end
      end
   end

   assign t  = q_ff[DIST_W];
   assign ok = !bad_ff[DIST_W] && !(negp_ff[DIST_W] && (q_ff[DIST_W] != '0));

endmodule

[design/bxr_face.sv]
// Hit point and containment check on one face for a candidate distance.
module bxr_face import bxr_pkg::*; #(
   parameter int CW  = 32,
   parameter int FB  = 16,
   parameter bit NEG = 1'b0
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [DIST_W-1:0]    t,
   input  logic                 ok,
   input  logic [DIST_W-1:0]    h_own,
   input  logic [1:0][CW-1:0]   o,
   input  logic [1:0][CW-1:0]   d,
   input  logic [1:0][DIST_W-1:0] h,
   output logic                 acc,
   output logic [DIST_W-1:0]    t_out,
   output logic [CW-1:0]        pos_own,
   output logic [1:0][CW-1:0]   pos
);

   localparam int PRW = DIST_W + 1 + CW;
   localparam int PSW = PRW + 1;

   logic signed [PRW-1:0] prod_ff [2];
   logic [CW-1:0]         o1_ff   [2];
   logic [DIST_W-1:0]     t1_ff;
   logic                  ok1_ff;
   logic [1:0]            in_box;
   logic [1:0][CW-1:0]    pos_in;
   logic [1:0][CW-1:0]    pos_ff;
   logic                  acc_ff;
   logic [DIST_W-1:0]     t2_ff;
   logic [CW-1:0]         h_cw;

   for (genvar i = 0; i < 2; i++) begin : g_lane
      logic signed [PRW-1:0] prod_in;
      logic signed [PRW-1:0] sh;
      logic signed [PSW-1:0] sum;
      logic signed [PSW-1:0] h_ext;

      always_comb begin
         prod_in = $signed({1'b0, t}) * $signed(d[i]);
         sh      = prod_ff[i] >>> FB;
         sum     = $signed({{(PSW-CW){o1_ff[i][CW-1]}}, o1_ff[i]}) + $signed({sh[PRW-1], sh});
         h_ext   = $signed({{(PSW-DIST_W){1'b0}}, h[i]});
         in_box[i] = (sum <= h_ext) && (sum >= -h_ext);
         pos_in[i] = sum[CW-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            prod_ff[i] <= prod_in;
            o1_ff[i]   <= o[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff  <= t;
         ok1_ff <= ok;
         pos_ff <= pos_in;
         acc_ff <= ok1_ff && in_box[0] && in_box[1];
         t2_ff  <= t1_ff;
      end
   end

   assign h_cw    = CW'(h_own);
   assign pos_own = NEG ? CW'(-h_cw) : h_cw;
   assign acc     = acc_ff;
   assign t_out   = t2_ff;
   assign pos     = pos_ff;

endmodule

[design/bxr_sel.sv]
// Six-stage chain that picks the closest accepted face in face order.
module bxr_sel import bxr_pkg::*; #(
   parameter int CW = 32
) (
   input  logic                                  clock,
   input  logic                                  adv,
   input  logic [DIST_W-1:0]                     maxd,
   input  logic [NUM_FACES-1:0]                  acc,
   input  logic [NUM_FACES-1:0][DIST_W-1:0]      t,
   input  logic [NUM_FACES-1:0][NUM_AXES-1:0][CW-1:0] pos,
   output logic                                  hit,
   output logic [2:0]                            face,
   output logic [DIST_W-1:0]                     distance,
   output logic [CW-1:0]                         hit_x,
   output logic [CW-1:0]                         hit_y,
   output logic [CW-1:0]                         hit_z
);

   logic [DIST_W-1:0]                      best_ff  [NUM_FACES];
   logic                                   found_ff [NUM_FACES];
   face_type                               face_ff  [NUM_FACES];
   logic [NUM_AXES-1:0][CW-1:0]            bpos_ff  [NUM_FACES];
   logic [NUM_FACES-1:0]                   cacc_ff  [NUM_FACES-1];
   logic [NUM_FACES-1:0][DIST_W-1:0]       ct_ff    [NUM_FACES-1];
   logic [NUM_FACES-1:0][NUM_AXES-1:0][CW-1:0] cpos_ff [NUM_FACES-1];

   for (genvar s = 0; s < NUM_FACES; s++) begin : g_stage
      logic [DIST_W-1:0]                      b_prev;
      logic                                   f_prev;
      face_type                               face_prev;
      logic [NUM_AXES-1:0][CW-1:0]            p_prev;
      logic [NUM_FACES-1:0]                   c_acc;
      logic [NUM_FACES-1:0][DIST_W-1:0]       c_t;
      logic [NUM_FACES-1:0][NUM_AXES-1:0][CW-1:0] c_pos;
      logic                                   take;

      if (s == 0) begin : g_first
         assign b_prev    = maxd;
         assign f_prev    = 1'b0;
         assign face_prev = FACE_PX;
         assign p_prev    = '0;
         assign c_acc     = acc;
         assign c_t       = t;
         assign c_pos     = pos;
      end else begin : g_next
         assign b_prev    = best_ff[s-1];
         assign f_prev    = found_ff[s-1];
         assign face_prev = face_ff[s-1];
         assign p_prev    = bpos_ff[s-1];
         assign c_acc     = cacc_ff[s-1];
         assign c_t       = ct_ff[s-1];
         assign c_pos     = cpos_ff[s-1];
      end

      assign take = c_acc[s] && (c_t[s] <= b_prev);

      always_ff @(posedge clock) begin
         if (adv) begin
            best_ff[s]  <= take ? c_t[s] : b_prev;
            found_ff[s] <= take | f_prev;
            face_ff[s]  <= take ? face_type'(3'(s)) : face_prev;
            bpos_ff[s]  <= take ? c_pos[s] : p_prev;
         end
      end

      if (s < NUM_FACES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               cacc_ff[s] <= c_acc;
               ct_ff[s]   <= c_t;
               cpos_ff[s] <= c_pos;
            end
         end
      end
   end

   assign hit      = found_ff[NUM_FACES-1];
   assign face     = hit ? face_ff[NUM_FACES-1] : FACE_PX;
   assign distance = hit ? best_ff[NUM_FACES-1] : '0;
   assign hit_x    = hit ? bpos_ff[NUM_FACES-1][0] : '0;
   assign hit_y    = hit ? bpos_ff[NUM_FACES-1][1] : '0;
   assign hit_z    = hit ? bpos_ff[NUM_FACES-1][2] : '0;

endmodule

[design/box_ray_hit.sv]
// Top level of the ray against origin-centered box hit test.
// One ray enters per clock while no stalled result holds the pipeline; each ray passes
// through the distance divider, which resolves one quotient bit per stage for
// all six faces in parallel, followed by two stages of hit point math and six stages
// that pick the closest face in order. A stalled result holds the whole pipeline.
module box_ray_hit import bxr_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_origin_z,
   input  logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_dir_z,
   input  logic [DIST_W-1:0]             req_max_distance,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [2:0]                    rsp_face,
   output logic [DIST_W-1:0]             rsp_distance,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_z,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [DIST_W-1:0]             csr_data
);

   localparam int CW       = COORD_WIDTH;
   localparam int FB       = FRAC_BITS;
   localparam int PW       = ((CW > DIST_W + 1) ? CW : DIST_W + 1) + 1;
   localparam int NW       = PW + FB;
   localparam int DIV_LAT  = DIST_W + 2;
   localparam int FACE_LAT = 2;
   localparam int LAT      = 1 + DIV_LAT + FACE_LAT + NUM_FACES;

   logic                adv;
   logic [LAT-1:0]      vld_ff;
   logic [DIST_W-1:0]   half_ff [NUM_AXES];
   logic [NUM_AXES-1:0][CW-1:0] org_ff [DIV_LAT+1];
   logic [NUM_AXES-1:0][CW-1:0] dir_ff [DIV_LAT+1];
   logic [DIST_W-1:0]   maxd_ff [DIV_LAT+FACE_LAT+1];

   logic [NUM_FACES-1:0]                   f_acc;
   logic [NUM_FACES-1:0][DIST_W-1:0]       f_t;
   logic [NUM_FACES-1:0][NUM_AXES-1:0][CW-1:0] f_pos;
   logic [CW-1:0]       sel_x;
   logic [CW-1:0]       sel_y;
   logic [CW-1:0]       sel_z;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAT-1];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff[0] <= HALF_RESET;
         half_ff[1] <= HALF_RESET;
         half_ff[2] <= HALF_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_type'(csr_index))
            CSR_HALF_X: half_ff[0] <= csr_data;
            CSR_HALF_Y: half_ff[1] <= csr_data;
            CSR_HALF_Z: half_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         org_ff[0]  <= {req_origin_z, req_origin_y, req_origin_x};
         dir_ff[0]  <= {req_dir_z, req_dir_y, req_dir_x};
         maxd_ff[0] <= req_max_distance;
         for (int k = 1; k <= DIV_LAT; k++) begin
            org_ff[k] <= org_ff[k-1];
            dir_ff[k] <= dir_ff[k-1];
         end
         for (int k = 1; k <= DIV_LAT + FACE_LAT; k++) begin
            maxd_ff[k] <= maxd_ff[k-1];
         end
      end
   end

   for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
      localparam int A  = f / 2;
      localparam int A1 = (A + 1) % NUM_AXES;
      localparam int A2 = (A + 2) % NUM_AXES;
      logic signed [PW-1:0] h_ext;
      logic signed [PW-1:0] plane;
      logic signed [PW-1:0] diff;
      logic signed [NW-1:0] num;
      logic [DIST_W-1:0]    d_t;
      logic                 d_ok;
      logic [CW-1:0]        p_own;
      logic [1:0][CW-1:0]   p_oth;

      always_comb begin
         h_ext = $signed({{(PW-DIST_W){1'b0}}, half_ff[A]});
         plane = (f % 2 == 1) ? -h_ext : h_ext;
         diff  = plane - $signed({{(PW-CW){org_ff[0][A][CW-1]}}, org_ff[0][A]});
         num   = $signed({diff, {FB{1'b0}}});
      end

      bxr_div #(
         .NUM_W (NW),
         .DEN_W (CW)
      ) u_div (
         .clock (clock),
         .adv   (adv),
         .num   (num),
         .den   ($signed(dir_ff[0][A])),
         .t     (d_t),
         .ok    (d_ok)
      );

      bxr_face #(
         .CW  (CW),
         .FB  (FB),
         .NEG (f % 2 == 1)
      ) u_face (
         .clock   (clock),
         .adv     (adv),
         .t       (d_t),
         .ok      (d_ok),
         .h_own   (half_ff[A]),
         .o       ({org_ff[DIV_LAT][A2], org_ff[DIV_LAT][A1]}),
         .d       ({dir_ff[DIV_LAT][A2], dir_ff[DIV_LAT][A1]}),
         .h       ({half_ff[A2], half_ff[A1]}),
         .acc     (f_acc[f]),
         .t_out   (f_t[f]),
         .pos_own (p_own),
         .pos     (p_oth)
      );

      assign f_pos[f][A]  = p_own;
      assign f_pos[f][A1] = p_oth[0];
      assign f_pos[f][A2] = p_oth[1];
   end

   bxr_sel #(
      .CW (CW)
   ) u_sel (
      .clock    (clock),
      .adv      (adv),
      .maxd     (maxd_ff[DIV_LAT+FACE_LAT]),
      .acc      (f_acc),
      .t        (f_t),
      .pos      (f_pos),
      .hit      (rsp_hit),
      .face     (rsp_face),
      .distance (rsp_distance),
      .hit_x    (sel_x),
      .hit_y    (sel_y),
      .hit_z    (sel_z)
   );

   assign rsp_hit_x = $signed(sel_x);
   assign rsp_hit_y = $signed(sel_y);
   assign rsp_hit_z = $signed(sel_z);

`ifndef SYNTHESIS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_face == FACE_PX && rsp_distance == '0 &&
         rsp_hit_x == '0 && rsp_hit_y == '0 && rsp_hit_z == '0)
      else $error("miss result carries nonzero fields");
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_face <= FACE_NZ)
      else $error("hit reports an unknown face");
   a_plane_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit && rsp_face == FACE_PX |-> rsp_hit_x == $signed(CW'(half_ff[0])))
      else $error("hit on the +x face is off its plane");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for the ray against origin-centered box hit test.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bxr_pkg::*;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int LATENCY = DIST_W + 11;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic          hit;
      logic [2:0]    face;
      logic [DIST_W-1:0] distance;
      logic [CW-1:0] hit_x;
      logic [CW-1:0] hit_y;
      logic [CW-1:0] hit_z;
   } hit_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [CW-1:0] req_origin_x = 0, req_origin_y = 0, req_origin_z = 0;
   logic signed [CW-1:0] req_dir_x = 0, req_dir_y = 0, req_dir_z = 0;
   logic [DIST_W-1:0] req_max_distance = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_hit;
   logic [2:0] rsp_face;
   logic [DIST_W-1:0] rsp_distance;
   logic signed [CW-1:0] rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HALF_X;
   logic [DIST_W-1:0] csr_data = 0;

   logic [DIST_W-1:0] box_half [NUM_AXES];
   hit_result_type expected_hits [$];
   int failures = 0;
   int idle_cycles = 0;
   bit stall_quiet = 0;

   box_ray_hit dut (.*);

   always #2 clock = ~clock;

   function automatic longint floor_shift(longint p);
      return p >>> FB;
   endfunction

   function automatic hit_result_type predict_hit(longint o[3], longint d[3], longint maxd);
      hit_result_type r;
      longint best, plane, t, p[3], h[3];
      int ax;
      bit in_box;
      r = '0;
      best = maxd;
      for (int k = 0; k < 3; k++) begin
         h[k] = longint'(box_half[k]);
      end
      for (int f = 0; f < NUM_FACES; f++) begin
         ax = f / 2;
         plane = (f % 2 == 0) ? h[ax] : -h[ax];
         if (d[ax] == 0) continue;
         t = ((plane - o[ax]) * (longint'(1) << FB)) / d[ax];
         if (t < 0 || t > best) continue;
         in_box = 1;
         for (int k = 0; k < 3; k++) begin
            if (k == ax) begin
               p[k] = plane;
            end else begin
               p[k] = o[k] + floor_shift(t * d[k]);
               if (p[k] > h[k] || p[k] < -h[k]) in_box = 0;
            end
         end
         if (!in_box) continue;
         best = t;
         r.hit = 1;
         r.face = f[2:0];
         r.distance = best[DIST_W-1:0];
         r.hit_x = p[0][CW-1:0];
         r.hit_y = p[1][CW-1:0];
         r.hit_z = p[2][CW-1:0];
      end
      return r;
   endfunction

   function automatic int short_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) :
             (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
   endfunction

   task automatic send_ray(logic [CW-1:0] ox, oy, oz, dx, dy, dz, logic [DIST_W-1:0] md,
                           bit gaps);
      longint o[3], d[3];
      int gap;
      o[0] = longint'($signed(ox)); o[1] = longint'($signed(oy));
      o[2] = longint'($signed(oz));
      d[0] = longint'($signed(dx)); d[1] = longint'($signed(dy));
      d[2] = longint'($signed(dz));
      gap = gaps ? short_gap() : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_origin_x <= ox; req_origin_y <= oy; req_origin_z <= oz;
      req_dir_x <= dx; req_dir_y <= dy; req_dir_z <= dz;
      req_max_distance <= md;
      do @(posedge clock); while (req_stall);
      expected_hits.push_back(predict_hit(o, d, longint'(md)));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_half(csr_type idx, logic [DIST_W-1:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      box_half[idx] = value;
   endtask

   task automatic set_box(logic [DIST_W-1:0] hx, hy, hz);
      drain();
      write_half(CSR_HALF_X, hx);
      write_half(CSR_HALF_Y, hy);
      write_half(CSR_HALF_Z, hz);
      csr_valid <= 0;
   endtask

   task automatic test_directed();
      logic [CW-1:0] one, two;
      one = 32'h0001_0000;
      two = 32'h0002_0000;
      // Axis-aligned rays from outside toward each face.
      send_ray(-two, 0, 0, one, 0, 0, 31'h7fff_ffff, 0);
      send_ray(two, 0, 0, -one, 0, 0, 31'h7fff_ffff, 0);
      send_ray(0, -two, 0, 0, one, 0, 31'h7fff_ffff, 0);
      send_ray(0, two, 0, 0, -one, 0, 31'h7fff_ffff, 0);
      send_ray(0, 0, -two, 0, 0, one, 31'h7fff_ffff, 0);
      send_ray(0, 0, two, 0, 0, -one, 31'h7fff_ffff, 0);
      // All direction components zero, so every face is skipped.
      send_ray(0, 0, 0, 0, 0, 0, 31'h7fff_ffff, 0);
      // Maximum distance zero and short of the box.
      send_ray(-two, 0, 0, one, 0, 0, 0, 0);
      send_ray(-two, 0, 0, one, 0, 0, 31'h0000_ffff, 0);
      // Diagonal ray through an edge, a tie between faces.
      send_ray(-two, -two, 0, one, one, 0, 31'h7fff_ffff, 0);
      // Grazing the box exactly on a bound.
      send_ray(-two, one, one, one, 0, 0, 31'h7fff_ffff, 0);
      send_ray(-two, one + 1, 0, one, 0, 0, 31'h7fff_ffff, 0);
      // Field extremes.
      send_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'h8000_0000, 32'h0000_0001, 31'h7fff_ffff, 0);
      send_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
               32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 0);
      send_ray(0, 0, 0, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 31'h7fff_ffff, 0);
      // Origin inside the box.
      send_ray(0, 0, 0, one, one, one, 31'h7fff_ffff, 0);
      drain();
      // Zero half extent: both faces of an axis share one plane.
      set_box(0, 31'h0002_0000, 31'h7fff_ffff);
      send_ray(-two, 0, 0, one, 0, 0, 31'h7fff_ffff, 0);
      send_ray(two, 0, 0, -one, 0, one, 31'h7fff_ffff, 0);
      set_box(31'h7fff_ffff, 31'h7fff_ffff, 0);
      send_ray(0, 0, two, 0, one, -one, 31'h7fff_ffff, 0);
      send_ray(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0, 31'h7fff_ffff, 0);
   endtask

   function automatic logic [CW-1:0] rand_coord(logic [DIST_W-1:0] scale);
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 2 * scale + 2) - scale - 1;
         default: return $urandom_range(0, 6 * scale + 2) - 3 * scale - 1;
      endcase
   endfunction

   task automatic test_random(int count);
      logic [CW-1:0] o[3], d[3], target, dir;
      logic [DIST_W-1:0] md, s;
      for (int i = 0; i < count; i++) begin
         s = box_half[$urandom_range(0, 2)];
         if (s > 31'h0100_0000 || s == 0) s = 31'h0004_0000;
         for (int k = 0; k < 3; k++) begin
            o[k] = rand_coord(s);
            d[k] = ($urandom_range(0, 7) == 0) ? 0 :
                   (($urandom_range(0, 4) == 0) ? $urandom() :
                    $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
         end
         // Mostly aim rays at a point near the center of the box.
         if ($urandom_range(0, 3) != 0) begin
            for (int k = 0; k < 3; k++) begin
               target = $urandom_range(0, 2 * box_half[k] / 4 + 2) - box_half[k] / 4 - 1;
               dir = (target - o[k]) >>> $urandom_range(0, 4);
               d[k] = dir;
            end
         end
         md = DIST_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31'h0004_0000) :
              (($urandom_range(0, 1) == 0) ? 32'h7fff_ffff : $urandom() >> 1));
         send_ray(o[0], o[1], o[2], d[0], d[1], d[2], md, 1);
      end
   endtask

   task automatic test_pause();
      test_random(30);
      req_valid <= 0;
      while (expected_hits.size() != 0) @(posedge clock);
      test_random(30);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result beat face %0d", $time, rsp_face);
               failures++;
            end else begin
               hit_result_type e;
               e = expected_hits.pop_front();
               if (rsp_hit !== e.hit) begin
                  $display("%0t: hit expected %0d actual %0d", $time, e.hit, rsp_hit);
                  failures++;
               end
               if (rsp_face !== e.face) begin
                  $display("%0t: face expected %0d actual %0d", $time, e.face, rsp_face);
                  failures++;
               end
               if (rsp_distance !== e.distance) begin
                  $display("%0t: distance expected %h actual %h", $time, e.distance,
                           rsp_distance);
                  failures++;
               end
               if (rsp_hit_x !== e.hit_x) begin
                  $display("%0t: hit_x expected %h actual %h", $time, e.hit_x, rsp_hit_x);
                  failures++;
               end
               if (rsp_hit_y !== e.hit_y) begin
                  $display("%0t: hit_y expected %h actual %h", $time, e.hit_y, rsp_hit_y);
                  failures++;
               end
               if (rsp_hit_z !== e.hit_z) begin
                  $display("%0t: hit_z expected %h actual %h", $time, e.hit_z, rsp_hit_z);
                  failures++;
               end
            end
         end
         if (stall_quiet || $urandom_range(0, 49) == 0) begin
            rsp_stall <= 0;
            if ($urandom_range(0, 199) == 0) stall_quiet <= ~stall_quiet;
         end else if ($urandom_range(0, 29) == 0) begin
            rsp_stall <= 1;
         end else if (!rsp_stall && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
         end else if (rsp_stall && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || (!req_valid && !csr_valid && expected_hits.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("box_ray_hit regression: fail");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < NUM_AXES; k++) box_half[k] = HALF_RESET;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      set_box(HALF_RESET, HALF_RESET, HALF_RESET);
      test_random(600);
      set_box(31'h0003_8000, 31'h0000_4000, 31'h0010_0000);
      test_pause();
      test_random(500);
      set_box(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
      test_random(300);
      set_box(0, 0, 0);
      test_random(150);
      set_box(DIST_W'($urandom() >> 1), DIST_W'($urandom_range(1, 32'h0008_0000)),
              DIST_W'($urandom_range(1, 32'h0008_0000)));
      test_random(350);
      drain();
      if (failures == 0)
         $display("box_ray_hit regression: pass");
      else
         $display("box_ray_hit regression: fail");
      $finish;
   end

endmodule
